// File: src/tcw_pkg.sv
// Package for the text console writer.
// Holds action codes, FSM states, character constants and the memory control struct.
`default_nettype none

package tcw_pkg;

  localparam int CURSOR_W = 11;
  localparam int POS_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SETPOS = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_SCROLL_PUT,
    ST_CLEAR,
    ST_WALK,
    ST_RDWAIT
  } st_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: src/tcw_if.sv
// Item channels of the text console writer: command in, status out.
// Depends on tcw_pkg for field widths.
`default_nettype none

interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::POS_W-1:0]     position;

  modport source (output valid, action, char_code, position, input ready);
  modport sink   (input valid, action, char_code, position, output ready);
endinterface

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell;
  logic                          scrolled;
  logic [tcw_pkg::CHAR_W-1:0]    cell_char;
  logic [tcw_pkg::ATTR_W-1:0]    cell_attr;

  modport source (output valid, cursor_cell, scrolled, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_cell, scrolled, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

// File: src/tcw_mem.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on tcw_pkg for the cell width and control struct.
`default_nettype none

module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic                        clk,
  input  wire tcw_pkg::mem_ctl_t           ctl,
  input  wire logic [AW-1:0]               rd_addr,
  output logic [tcw_pkg::CELL_W-1:0]       rd_data,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wr_data
);

  logic [tcw_pkg::CELL_W-1:0] cells_r [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// Sequencer of the text console writer: cursor, row base, scroll and clear sweeps.
// Depends on tcw_pkg and drives tcw_mem through a registered write stage.
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
  tcw_in_if.sink                    in_ch,
  tcw_out_if.source                 out_ch
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = (CW > tcw_pkg::POS_W) ? CW : tcw_pkg::POS_W;

  tcw_pkg::st_t  state_r, state_nxt;
  tcw_pkg::act_t act_r;
  logic [tcw_pkg::CHAR_W-1:0] ch_r;
  logic [tcw_pkg::POS_W-1:0]  pos_r;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] rb_r, rb_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic                       wr_en_r, wr_en_nxt;
  logic [AW-1:0]              wr_addr_r, wr_addr_nxt;
  logic                       wr_copy_r, wr_copy_nxt;
  logic [tcw_pkg::CHAR_W-1:0] wr_char_r, wr_char_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CURSOR_W-1:0] out_cursor_r, out_cursor_nxt;
  logic                         out_scrolled_r, out_scrolled_nxt;
  logic [tcw_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]   out_attr_r, out_attr_nxt;

  tcw_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]              rd_addr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;
  logic [tcw_pkg::CELL_W-1:0] wr_data;

  logic          in_ready;
  logic          in_acc;
  logic          at_end;
  logic          last_idx;
  logic          copy_zone;
  logic          is_nl;
  logic [CW:0]   rb_plus_w;
  logic [CW-1:0] rb_plus;
  logic [CW-1:0] cur_inc;
  logic [CW-1:0] put_cursor;
  logic [CW-1:0] put_rb;
  logic [PW-1:0] pos_ext;
  logic          pos_over;
  logic          pos_in;
  logic [CW-1:0] sat_pos;
  logic          walk_step;
  logic          done;
  logic [PW-1:0] cur_out_ext;

  assign in_ready = (state_r == tcw_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc   = in_ch.valid && in_ready;

  assign at_end    = (cursor_r == CW'(CELLS));
  assign last_idx  = (idx_r == AW'(CELLS - 1));
  assign copy_zone = (idx_r < AW'(CELLS - COLUMNS));

  assign is_nl      = (ch_r == tcw_pkg::NEWLINE_CHAR);
  assign rb_plus_w  = (CW+1)'(rb_r) + (CW+1)'(COLUMNS);
  assign rb_plus    = rb_plus_w[CW-1:0];
  assign cur_inc    = cursor_r + CW'(1);
  assign put_cursor = is_nl ? rb_plus : cur_inc;
  assign put_rb     = (is_nl || (cur_inc == rb_plus)) ? put_cursor : rb_r;

  assign pos_ext    = PW'(pos_r);
  assign pos_over   = (pos_ext > PW'(CELLS));
  assign pos_in     = (pos_ext < PW'(CELLS));
  assign sat_pos    = pos_over ? CW'(CELLS) : CW'(pos_ext);
  assign walk_step  = (rb_plus_w <= (CW+1)'(cursor_r));

  assign wr_data = wr_copy_r ? rd_data : {attr, wr_char_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        case (act_r)
          tcw_pkg::ACT_PUT:    state_nxt = at_end ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_IDLE;
          tcw_pkg::ACT_CLEAR:  state_nxt = tcw_pkg::ST_CLEAR;
          tcw_pkg::ACT_SETPOS: state_nxt = tcw_pkg::ST_WALK;
          tcw_pkg::ACT_READ:   state_nxt = pos_in ? tcw_pkg::ST_RDWAIT : tcw_pkg::ST_IDLE;
          default:             state_nxt = tcw_pkg::ST_IDLE;
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        if (last_idx) begin
          state_nxt = tcw_pkg::ST_SCROLL_PUT;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (last_idx) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_WALK: begin
        if (!walk_step) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL_PUT: state_nxt = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_RDWAIT:     state_nxt = tcw_pkg::ST_IDLE;
      default:                state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cursor_nxt       = cursor_r;
    rb_nxt           = rb_r;
    idx_nxt          = idx_r;
    wr_en_nxt        = 1'b0;
    wr_addr_nxt      = wr_addr_r;
    wr_copy_nxt      = 1'b0;
    wr_char_nxt      = wr_char_r;
    mem_ctl.rd_en    = 1'b0;
    rd_addr          = AW'(pos_ext);
    done             = 1'b0;
    out_scrolled_nxt = 1'b0;
    out_char_nxt     = '0;
    out_attr_nxt     = '0;

    case (state_r)
      tcw_pkg::ST_DECODE: begin
        idx_nxt = '0;
        case (act_r)
          tcw_pkg::ACT_PUT: begin
            if (!at_end) begin
              cursor_nxt  = put_cursor;
              rb_nxt      = put_rb;
              wr_en_nxt   = !is_nl;
              wr_addr_nxt = AW'(cursor_r);
              wr_char_nxt = ch_r;
              done        = 1'b1;
            end
          end
          tcw_pkg::ACT_CLEAR: begin
            cursor_nxt = '0;
            rb_nxt     = '0;
          end
          tcw_pkg::ACT_SETPOS: begin
            cursor_nxt = sat_pos;
            rb_nxt     = '0;
          end
          tcw_pkg::ACT_READ: begin
            mem_ctl.rd_en = pos_in;
            done          = !pos_in;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        mem_ctl.rd_en = copy_zone;
        rd_addr       = idx_r + AW'(COLUMNS);
        wr_en_nxt     = 1'b1;
        wr_addr_nxt   = idx_r;
        wr_copy_nxt   = copy_zone;
        wr_char_nxt   = tcw_pkg::BLANK_CHAR;
        idx_nxt       = idx_r + AW'(1);
        if (last_idx) begin
          cursor_nxt = CW'(CELLS - COLUMNS);
          rb_nxt     = CW'(CELLS - COLUMNS);
        end
      end
      tcw_pkg::ST_SCROLL_PUT: begin
        cursor_nxt       = put_cursor;
        rb_nxt           = put_rb;
        wr_en_nxt        = !is_nl;
        wr_addr_nxt      = AW'(cursor_r);
        wr_char_nxt      = ch_r;
        out_scrolled_nxt = 1'b1;
        done             = 1'b1;
      end
      tcw_pkg::ST_CLEAR: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = idx_r;
        wr_char_nxt = tcw_pkg::BLANK_CHAR;
        idx_nxt     = idx_r + AW'(1);
        done        = last_idx;
      end
      tcw_pkg::ST_WALK: begin
        if (walk_step) begin
          rb_nxt = rb_plus;
        end else begin
          done = 1'b1;
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        out_char_nxt = rd_data[tcw_pkg::CHAR_W-1:0];
        out_attr_nxt = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        done         = 1'b1;
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase

    mem_ctl.wr_en  = wr_en_r;
    cur_out_ext    = PW'(cursor_nxt);
    out_cursor_nxt = done ? cur_out_ext[tcw_pkg::CURSOR_W-1:0] : out_cursor_r;
    if (!done) begin
      out_scrolled_nxt = out_scrolled_r;
      out_char_nxt     = out_char_r;
      out_attr_nxt     = out_attr_r;
    end
    out_valid_nxt = done || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      cursor_r    <= '0;
      rb_r        <= '0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      rb_r        <= rb_nxt;
      wr_en_r     <= wr_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= tcw_pkg::act_t'(in_ch.action);
      ch_r  <= in_ch.char_code;
      pos_r <= in_ch.position;
    end
    idx_r          <= idx_nxt;
    wr_addr_r      <= wr_addr_nxt;
    wr_copy_r      <= wr_copy_nxt;
    wr_char_r      <= wr_char_nxt;
    out_cursor_r   <= out_cursor_nxt;
    out_scrolled_r <= out_scrolled_nxt;
    out_char_r     <= out_char_nxt;
    out_attr_r     <= out_attr_nxt;
  end

  tcw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_cell = out_cursor_r;
  assign out_ch.scrolled    = out_scrolled_r;
  assign out_ch.cell_char   = out_char_r;
  assign out_ch.cell_attr   = out_attr_r;

endmodule

`default_nettype wire

// File: src/text_console_writer_unit.sv
// After accept, a put or an out-of-range read ends in the decode state; an in-range read
// adds the registered memory read, and set cursor walks the row base up to the saturated
// position. Items are taken only in idle with the result slot empty or being taken. Clear
// screen sweeps the cell memory one cell per cycle, as does the scroll ahead of its put.
// Synchronous active-low reset: cursor 0, attribute 15, output empty; the cell memory is
// not cleared.
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_in_if.sink                          in_ch,
  tcw_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  logic [tcw_pkg::ATTR_W-1:0] attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .attr   (attr_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: src/tcw_checker.sv
// Port-level checks for text_console_writer_unit, attached with bind.
// Depends on tcw_pkg for field widths.
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [tcw_pkg::CURSOR_W-1:0] out_cursor_cell,
  input wire logic                         out_scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam bit NARROW = (CELLS < 2048);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item accepted while busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NARROW |-> 32'(out_cursor_cell) <= CELLS)
    else $error("cursor past screen end");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled && NARROW |-> 32'(out_cursor_cell) > CELLS - COLUMNS)
    else $error("cursor not on last row after scroll");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cursor_cell (out_ch.cursor_cell),
  .out_scrolled    (out_ch.scrolled)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for text_console_writer_unit: predicts cursor, scroll and read-back status
// per command item and checks each status item in order. Needs tcw_pkg, tcw_if and the RTL.
module tb;

  localparam int COLS  = 80;
  localparam int NROWS = 25;
  localparam int CELLS = COLS * NROWS;

  typedef struct {
    tcw_pkg::act_t                  action;
    logic [tcw_pkg::CHAR_W-1:0]     char_code;
    logic [tcw_pkg::POS_W-1:0]      position;
  } cmd_t;

  typedef struct {
    logic [tcw_pkg::CURSOR_W-1:0]   cursor_cell;
    logic                           scrolled;
    logic [tcw_pkg::CHAR_W-1:0]     cell_char;
    logic [tcw_pkg::ATTR_W-1:0]     cell_attr;
  } status_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata;

  tcw_in_if  in_if();
  tcw_out_if out_if();

  text_console_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // screen shadow
  logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
  int unsigned                cur_pos;
  logic [tcw_pkg::ATTR_W-1:0] attr_now;

  cmd_t    cmd_backlog[$];
  status_t status_due[$];
  int      cmds_queued;
  int      cmds_taken;
  int      errors;
  int      snd_idle;
  int      rcv_idle;
  logic    in_taken;
  logic    rx_hold;
  logic    hold_go;
  logic    hold_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic status_t console_step(cmd_t c);
    status_t r;
    r.scrolled  = 1'b0;
    r.cell_char = '0;
    r.cell_attr = '0;
    case (c.action)
      tcw_pkg::ACT_PUT: begin
        if (cur_pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr_now, tcw_pkg::BLANK_CHAR};
          cur_pos    = (cur_pos >= COLS) ? cur_pos - COLS : 0;
          r.scrolled = 1'b1;
        end
        if (c.char_code == tcw_pkg::NEWLINE_CHAR) begin
          cur_pos = (cur_pos / COLS + 1) * COLS;
          if (cur_pos > CELLS) cur_pos = CELLS;
        end else if (cur_pos < CELLS) begin
          screen[cur_pos] = {attr_now, c.char_code};
          cur_pos++;
        end
      end
      tcw_pkg::ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {attr_now, tcw_pkg::BLANK_CHAR};
        cur_pos = 0;
      end
      tcw_pkg::ACT_SETPOS: begin
        cur_pos = (c.position > CELLS) ? CELLS : c.position;
      end
      tcw_pkg::ACT_READ: begin
        if (c.position < CELLS) begin
          r.cell_char = screen[c.position][tcw_pkg::CHAR_W-1:0];
          r.cell_attr = screen[c.position][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
      end
      default: begin
        r.scrolled = 1'b0;
      end
    endcase
    r.cursor_cell = cur_pos[tcw_pkg::CURSOR_W-1:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= snd_idle) begin
        c = cmd_backlog.pop_front();
        in_if.valid     <= 1'b1;
        in_if.action    <= c.action;
        in_if.char_code <= c.char_code;
        in_if.position  <= c.position;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cmd_t    c;
    status_t e;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: unexpected status item: expected none, got cursor %0d",
                   $time, out_if.cursor_cell);
          errors++;
        end else begin
          e = status_due.pop_front();
          if (out_if.cursor_cell !== e.cursor_cell) begin
            $display("%0t: cursor_cell expected %0d got %0d", $time, e.cursor_cell,
                     out_if.cursor_cell);
            errors++;
          end
          if (out_if.scrolled !== e.scrolled) begin
            $display("%0t: scrolled expected %0b got %0b", $time, e.scrolled, out_if.scrolled);
            errors++;
          end
          if (out_if.cell_char !== e.cell_char) begin
            $display("%0t: cell_char expected %0h got %0h", $time, e.cell_char,
                     out_if.cell_char);
            errors++;
          end
          if (out_if.cell_attr !== e.cell_attr) begin
            $display("%0t: cell_attr expected %0h got %0h", $time, e.cell_attr,
                     out_if.cell_attr);
            errors++;
          end
        end
      end
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        c.action    = tcw_pkg::act_t'(in_if.action);
        c.char_code = in_if.char_code;
        c.position  = in_if.position;
        status_due.push_back(console_step(c));
        cmds_taken++;
      end
    end
  end

  // long receiver hold-off
  initial begin
    rx_hold   = 1'b0;
    hold_done = 1'b0;
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold   = 1'b0;
    hold_done = 1'b1;
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_cmd(tcw_pkg::act_t a, logic [tcw_pkg::CHAR_W-1:0] ch,
                           logic [tcw_pkg::POS_W-1:0] pos);
    cmd_t c;
    c.action    = a;
    c.char_code = ch;
    c.position  = pos;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_random(int n);
    int                         sel;
    tcw_pkg::act_t              a;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::POS_W-1:0]  pos;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      ch  = tcw_pkg::CHAR_W'($urandom_range(255));
      pos = tcw_pkg::POS_W'($urandom_range(2047));
      if (sel < 58) begin
        a = tcw_pkg::ACT_PUT;
        if ($urandom_range(99) < 15) ch = tcw_pkg::NEWLINE_CHAR;
      end else if (sel < 61) begin
        a = tcw_pkg::ACT_CLEAR;
      end else if (sel < 76) begin
        a = tcw_pkg::ACT_SETPOS;
        if ($urandom_range(99) < 40) pos = tcw_pkg::POS_W'($urandom_range(2047, 1900));
      end else begin
        a = tcw_pkg::ACT_READ;
      end
      queue_cmd(a, ch, pos);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (cmds_taken != cmds_queued || status_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_attr(logic [tcw_pkg::ATTR_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    attr_now   = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.action    = '0;
    in_if.char_code = '0;
    in_if.position  = '0;
    out_if.ready    = 1'b0;
    hold_go         = 1'b0;
    errors          = 0;
    cmds_queued     = 0;
    cmds_taken      = 0;
    cur_pos         = 0;
    attr_now        = tcw_pkg::ATTR_RESET;
    snd_idle        = 25;
    rcv_idle        = 71;
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // only cells written since reset are read back before the first clear
    queue_cmd(tcw_pkg::ACT_PUT, 8'h41, 11'd0);
    queue_cmd(tcw_pkg::ACT_PUT, 8'h00, 11'd2047);
    queue_cmd(tcw_pkg::ACT_PUT, 8'hFF, 11'd0);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::ACT_READ, 8'hFF, 11'd1);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd2);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd2000);
    queue_cmd(tcw_pkg::ACT_READ, 8'hFF, 11'd2047);
    queue_cmd(tcw_pkg::ACT_SETPOS, 8'h00, 11'd2047);
    queue_cmd(tcw_pkg::ACT_SETPOS, 8'h00, 11'd2000);
    queue_cmd(tcw_pkg::ACT_CLEAR, 8'hFF, 11'd2047);
    queue_cmd(tcw_pkg::ACT_SETPOS, 8'h00, 11'd1999);
    queue_cmd(tcw_pkg::ACT_PUT, 8'h5A, 11'd0);
    queue_cmd(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);
    queue_cmd(tcw_pkg::ACT_PUT, 8'h78, 11'd0);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd1999);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd1839);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd1920);
    queue_cmd(tcw_pkg::ACT_SETPOS, 8'h00, 11'd1920);
    queue_cmd(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);
    queue_cmd(tcw_pkg::ACT_SETPOS, 8'h00, 11'd5);
    queue_cmd(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::ACT_READ, 8'h00, 11'd80);
    drain();

    set_attr(8'h00);
    queue_random(480);
    drain();

    snd_idle = 71;
    rcv_idle = 25;
    set_attr(8'hFF);
    queue_random(480);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    set_attr(tcw_pkg::ATTR_W'($urandom_range(254, 1)));
    for (int k = 0; k < 60; k++) begin
      queue_cmd(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_W'($urandom_range(255, 11)),
                tcw_pkg::POS_W'($urandom_range(2047)));
    end
    hold_go = 1'b1;
    wait (hold_done);
    drain();

    set_attr(tcw_pkg::ATTR_W'($urandom_range(254, 1)));
    queue_random(210);
    drain();
    set_attr(tcw_pkg::ATTR_W'($urandom_range(254, 1)));
    queue_random(196);
    drain();

    repeat (CELLS + 20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
